// ===== hdl/pce_pkg.sv =====
package pce_pkg;

  // Sample width and series capacity.
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS   = 4096;

  // Widths of the running sums and of the series-end terms.
  localparam int N_BITS = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W  = SAMPLE_BITS + N_BITS;
  localparam int PR_W   = 2 * SAMPLE_BITS;
  localparam int SQ_W   = PR_W + N_BITS - 1;
  localparam int XY_W   = PR_W + N_BITS;
  localparam int VAR_W  = N_BITS + SQ_W;
  localparam int NUM_W  = N_BITS + XY_W;
  localparam int MAG_W  = NUM_W - 1;
  localparam int MP_W   = (VAR_W > MAG_W) ? VAR_W : MAG_W;
  localparam int PV_W   = 2 * MP_W;
  localparam int ACC_W  = PV_W + 1;
  localparam int CNT_W  = $clog2(MP_W + 1);

  // Q1.15 result: the squared ratio is a 2*FRAC_BITS+1 bit quotient.
  localparam int FRAC_BITS = 15;
  localparam int CORR_W    = FRAC_BITS + 1;
  localparam int Q_W       = 2 * FRAC_BITS + 1;
  localparam int R_W       = FRAC_BITS + 1;
  localparam int SQ_IT_W   = $clog2(R_W + 1);

  localparam logic signed [CORR_W-1:0] CORR_MAX = CORR_W'((2 ** FRAC_BITS) - 1);

  // Status codes of a result word.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FLAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic                          last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [STATUS_W-1:0]      status;
    logic [N_BITS-1:0]        pairs_used;
  } out_item_t;

  // Running series state handed from the accumulator to the finisher.
  typedef struct packed {
    logic [N_BITS-1:0]       pair_count;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [XY_W-1:0]  sum_xy;
    logic [SQ_W-1:0]         sum_xx;
    logic [SQ_W-1:0]         sum_yy;
    logic                    overflow;
  } sums_t;

endpackage

// ===== hdl/pearson_correlation_engine_unit.sv =====
// Streaming Pearson correlation of paired signed samples.
//
// Input channel (in_valid/in_ready/in_data): one word per sample pair.
// Words accumulate into a pair count and exact sums of x, y, x*y, x*x and
// y*y. A word with last_pair set closes the series.
// Result channel (out_valid/out_ready/out_data): one word per series with
// the coefficient in signed Q1.15, a status (valid, flat, too many pairs)
// and the number of pairs used. Sums clear once the result is registered.
//
// Timing: each accepted pair keeps the block busy while the one 16x16
// multiplier forms x*y, x*x and y*y in turn, so a new word is taken only
// once the previous pair is through. A closing pair then passes through
// the wide shift-add unit: three n*A - B*C terms, two 57x57 products, a
// 31-step division and a 16-step root. Flat series finish after the terms,
// overflowed ones at once. in_ready is low while either part is busy.
// The result sits in an output register; a stalled receiver only blocks a
// following series end. Reset (rst_n low, synchronous) empties the output
// and clears all sums.
module pearson_correlation_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pce_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pce_pkg::out_item_t  out_data
);
  import pce_pkg::*;

  logic           in_fire;
  logic           acc_busy;
  logic           series_end;
  sums_t          sums;
  logic           fin_busy;
  logic           res_valid;
  logic           res_ready;
  out_item_t      res;
  logic           clr;
  logic           sq_start;
  logic [Q_W-1:0] sq_radicand;
  logic           sq_done;
  logic [R_W-1:0] sq_root;
  logic           out_valid_r;
  out_item_t      out_data_r;

  assign in_ready  = !acc_busy && !fin_busy;
  assign in_fire   = in_valid && in_ready;
  assign res_ready = !out_valid_r || out_ready;

  pce_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .item       (in_data),
    .clr        (clr),
    .busy       (acc_busy),
    .series_end (series_end),
    .sums       (sums)
  );

  pce_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (series_end),
    .sums        (sums),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res),
    .busy        (fin_busy),
    .clr         (clr),
    .sq_start    (sq_start),
    .sq_radicand (sq_radicand),
    .sq_done     (sq_done),
    .sq_root     (sq_root)
  );

  pce_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Output register decouples the finisher from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/pce_accum.sv =====
module pce_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pce_pkg::in_item_t item,
  input  logic             clr,
  output logic             busy,
  output logic             series_end,
  output pce_pkg::sums_t   sums
);
  import pce_pkg::*;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_P0   = 3'd1;
  localparam logic [2:0] A_P1   = 3'd2;
  localparam logic [2:0] A_P2   = 3'd3;
  localparam logic [2:0] A_P3   = 3'd4;

  logic [2:0]                    state_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          last_r;
  logic                          skip_r;
  logic signed [PR_W-1:0]        prod_r;
  logic signed [PR_W-1:0]        prod_nxt;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  sums_t                         sums_r;

  // One multiplier serves the cross product and both squares in turn.
  always_comb begin
    unique case (state_r)
      A_P0: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      A_P1: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = y_r;
        mul_b = y_r;
      end
    endcase
    prod_nxt = PR_W'(mul_a) * PR_W'(mul_b);
  end

  // Each product is registered in prod_r and added into its sum from there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      sums_r  <= '0;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          if (clr) begin
            sums_r <= '0;
          end
          if (start) begin
            x_r     <= item.sample_x;
            y_r     <= item.sample_y;
            last_r  <= item.last_pair;
            skip_r  <= (sums_r.pair_count == N_BITS'(MAX_PAIRS));
            state_r <= A_P0;
          end
        end
        A_P0: begin
          prod_r <= prod_nxt;
          if (skip_r) begin
            sums_r.overflow <= 1'b1;
          end else begin
            sums_r.pair_count <= sums_r.pair_count + N_BITS'(1);
            sums_r.sum_x      <= sums_r.sum_x + SUM_W'(x_r);
            sums_r.sum_y      <= sums_r.sum_y + SUM_W'(y_r);
          end
          state_r <= A_P1;
        end
        A_P1: begin
          prod_r <= prod_nxt;
          if (!skip_r) begin
            sums_r.sum_xy <= sums_r.sum_xy + XY_W'(prod_r);
          end
          state_r <= A_P2;
        end
        A_P2: begin
          prod_r <= prod_nxt;
          if (!skip_r) begin
            sums_r.sum_xx <= sums_r.sum_xx + SQ_W'(prod_r);
          end
          state_r <= A_P3;
        end
        A_P3: begin
          if (!skip_r) begin
            sums_r.sum_yy <= sums_r.sum_yy + SQ_W'(prod_r);
          end
          state_r <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != A_IDLE);
  assign series_end = (state_r == A_P3) && last_r;
  assign sums       = sums_r;

endmodule

// ===== hdl/pce_isqrt.sv =====
module pce_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pce_pkg::Q_W-1:0]   radicand,
  output logic                      done,
  output logic [pce_pkg::R_W-1:0]   root
);
  import pce_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [Q_W-1:0]     op_r;
  logic [Q_W:0]       res_r;
  logic [Q_W-1:0]     one_r;
  logic [SQ_IT_W-1:0] it_r;
  logic [Q_W:0]       trial;
  logic               take;

  // Digit-by-digit square root, one result bit per cycle.
  assign trial = res_r + (Q_W + 1)'(one_r);
  assign take  = ({1'b0, op_r} >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        op_r   <= radicand;
        res_r  <= '0;
        one_r  <= Q_W'(1) << (2 * (R_W - 1));
        it_r   <= SQ_IT_W'(R_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (take) begin
          op_r  <= op_r - trial[Q_W-1:0];
          res_r <= (res_r >> 1) + (Q_W + 1)'(one_r);
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        it_r  <= it_r - SQ_IT_W'(1);
        if (it_r == SQ_IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[R_W-1:0];

endmodule

// ===== hdl/pce_finish.sv =====
module pce_finish (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  pce_pkg::sums_t           sums,
  input  logic                     res_ready,
  output logic                     res_valid,
  output pce_pkg::out_item_t       res,
  output logic                     busy,
  output logic                     clr,
  output logic                     sq_start,
  output logic [pce_pkg::Q_W-1:0]  sq_radicand,
  input  logic                     sq_done,
  input  logic [pce_pkg::R_W-1:0]  sq_root
);
  import pce_pkg::*;

  localparam logic [3:0] F_IDLE      = 4'd0;
  localparam logic [3:0] F_LOAD      = 4'd1;
  localparam logic [3:0] F_MUL       = 4'd2;
  localparam logic [3:0] F_STORE     = 4'd3;
  localparam logic [3:0] F_DIV_INIT  = 4'd4;
  localparam logic [3:0] F_DIV       = 4'd5;
  localparam logic [3:0] F_SQRT_GO   = 4'd6;
  localparam logic [3:0] F_SQRT_WAIT = 4'd7;
  localparam logic [3:0] F_DONE      = 4'd8;

  // Product phases: three terms, each n*A less B*C, then vx*vy and num^2.
  localparam logic [2:0] PH_NXY = 3'd0;
  localparam logic [2:0] PH_SXY = 3'd1;
  localparam logic [2:0] PH_NXX = 3'd2;
  localparam logic [2:0] PH_SXX = 3'd3;
  localparam logic [2:0] PH_NYY = 3'd4;
  localparam logic [2:0] PH_SYY = 3'd5;
  localparam logic [2:0] PH_PV  = 3'd6;
  localparam logic [2:0] PH_N2  = 3'd7;

  logic [3:0]              state_r;
  logic [2:0]              ph_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        mcand_r;
  logic [MP_W-1:0]         mplier_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    msb_neg_r;
  logic                    sub_r;
  logic signed [NUM_W-1:0] num_r;
  logic [VAR_W-1:0]        vx_r;
  logic [VAR_W-1:0]        vy_r;
  logic [PV_W-1:0]         pv_r;
  logic                    fb_r;
  logic [Q_W-1:0]          q_r;
  logic                    neg_r;
  out_item_t               res_r;

  logic [ACC_W-1:0]        ld_mcand;
  logic [MP_W-1:0]         ld_mplier;
  logic [CNT_W-1:0]        ld_cnt;
  logic                    ld_msb;
  logic                    ld_sub;
  logic                    ld_clear;
  logic [NUM_W-1:0]        num_abs;
  logic [MAG_W-1:0]        num_mag;
  logic                    step_neg;
  logic [ACC_W-1:0]        add_res;
  logic [ACC_W-1:0]        div_sh;
  logic [ACC_W:0]          div_diff;
  logic                    div_ge;
  logic [VAR_W-1:0]        acc_var;
  logic signed [CORR_W-1:0] corr_val;

  assign num_abs = num_r[NUM_W-1] ? NUM_W'(-num_r) : num_r;
  assign num_mag = num_abs[MAG_W-1:0];
  assign acc_var = acc_r[VAR_W-1:0];

  // Operand selection for each product phase.
  always_comb begin
    ld_msb   = 1'b0;
    ld_sub   = 1'b0;
    ld_clear = 1'b1;
    unique case (ph_r)
      PH_NXY: begin
        ld_mcand  = ACC_W'(sums.sum_xy);
        ld_mplier = MP_W'(sums.pair_count);
        ld_cnt    = CNT_W'(N_BITS);
      end
      PH_SXY: begin
        ld_mcand  = ACC_W'(sums.sum_x);
        ld_mplier = MP_W'($unsigned(sums.sum_y));
        ld_cnt    = CNT_W'(SUM_W);
        ld_msb    = 1'b1;
        ld_sub    = 1'b1;
        ld_clear  = 1'b0;
      end
      PH_NXX: begin
        ld_mcand  = ACC_W'(sums.sum_xx);
        ld_mplier = MP_W'(sums.pair_count);
        ld_cnt    = CNT_W'(N_BITS);
      end
      PH_SXX: begin
        ld_mcand  = ACC_W'(sums.sum_x);
        ld_mplier = MP_W'($unsigned(sums.sum_x));
        ld_cnt    = CNT_W'(SUM_W);
        ld_msb    = 1'b1;
        ld_sub    = 1'b1;
        ld_clear  = 1'b0;
      end
      PH_NYY: begin
        ld_mcand  = ACC_W'(sums.sum_yy);
        ld_mplier = MP_W'(sums.pair_count);
        ld_cnt    = CNT_W'(N_BITS);
      end
      PH_SYY: begin
        ld_mcand  = ACC_W'(sums.sum_y);
        ld_mplier = MP_W'($unsigned(sums.sum_y));
        ld_cnt    = CNT_W'(SUM_W);
        ld_msb    = 1'b1;
        ld_sub    = 1'b1;
        ld_clear  = 1'b0;
      end
      PH_PV: begin
        ld_mcand  = ACC_W'(vx_r);
        ld_mplier = MP_W'(vy_r);
        ld_cnt    = CNT_W'(VAR_W);
      end
      default: begin
        ld_mcand  = ACC_W'(num_mag);
        ld_mplier = MP_W'(num_mag);
        ld_cnt    = CNT_W'(MAG_W);
      end
    endcase
  end

  // Shared wide adder: shift-add multiply step that subtracts for B*C, with
  // the top multiplier bit weighted negative for signed operands.
  assign step_neg = sub_r ^ (msb_neg_r && (cnt_r == CNT_W'(1)));
  assign add_res  = step_neg ? (acc_r - mcand_r) : (acc_r + mcand_r);

  // Restoring division step on the same wide word.
  assign div_sh   = {acc_r[ACC_W-2:0], fb_r};
  assign div_diff = {1'b0, div_sh} - {1'b0, ACC_W'(pv_r)};
  assign div_ge   = !div_diff[ACC_W];

  // Sign the root; a positive full-scale result saturates.
  always_comb begin
    if (neg_r) begin
      corr_val = CORR_W'(-sq_root);
    end else if (sq_root > $unsigned(CORR_MAX)) begin
      corr_val = CORR_MAX;
    end else begin
      corr_val = CORR_W'(sq_root);
    end
  end

  // Series-end sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            res_r.pairs_used <= sums.pair_count;
            neg_r            <= 1'b0;
            if (sums.overflow) begin
              res_r.correlation <= '0;
              res_r.status      <= ST_OVF;
              state_r           <= F_DONE;
            end else begin
              ph_r    <= PH_NXY;
              state_r <= F_LOAD;
            end
          end
        end
        F_LOAD: begin
          mcand_r   <= ld_mcand;
          mplier_r  <= ld_mplier;
          cnt_r     <= ld_cnt;
          msb_neg_r <= ld_msb;
          sub_r     <= ld_sub;
          if (ld_clear) begin
            acc_r <= '0;
          end
          state_r <= F_MUL;
        end
        F_MUL: begin
          if (mplier_r[0]) begin
            acc_r <= add_res;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= F_STORE;
          end
        end
        F_STORE: begin
          ph_r    <= ph_r + 3'd1;
          state_r <= F_LOAD;
          unique case (ph_r)
            PH_SXY: begin
              num_r <= acc_r[NUM_W-1:0];
            end
            PH_SXX: begin
              vx_r <= acc_var;
            end
            PH_SYY: begin
              vy_r <= acc_var;
              if ((vx_r == '0) || (acc_var == '0)) begin
                res_r.correlation <= '0;
                res_r.status      <= ST_FLAT;
                state_r           <= F_DONE;
              end
            end
            PH_PV: begin
              pv_r  <= acc_r[PV_W-1:0];
              neg_r <= num_r[NUM_W-1];
            end
            PH_N2: begin
              state_r <= F_DIV_INIT;
            end
            default: begin
            end
          endcase
        end
        F_DIV_INIT: begin
          // The dividend is the squared numerator shifted up by 2*FRAC_BITS.
          fb_r    <= acc_r[0];
          acc_r   <= acc_r >> 1;
          cnt_r   <= CNT_W'(Q_W);
          q_r     <= '0;
          state_r <= F_DIV;
        end
        F_DIV: begin
          acc_r <= div_ge ? div_diff[ACC_W-1:0] : div_sh;
          q_r   <= {q_r[Q_W-2:0], div_ge};
          fb_r  <= 1'b0;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= F_SQRT_GO;
          end
        end
        F_SQRT_GO: begin
          state_r <= F_SQRT_WAIT;
        end
        F_SQRT_WAIT: begin
          if (sq_done) begin
            res_r.correlation <= corr_val;
            res_r.status      <= ST_VALID;
            state_r           <= F_DONE;
          end
        end
        F_DONE: begin
          if (res_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  assign res_valid   = (state_r == F_DONE);
  assign res         = res_r;
  assign busy        = (state_r != F_IDLE);
  assign clr         = (state_r == F_DONE) && res_ready;
  assign sq_start    = (state_r == F_SQRT_GO);
  assign sq_radicand = q_r;

endmodule

// ===== hdl/pce_checker.sv =====
module pce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pce_pkg::out_item_t out_data
);
  import pce_pkg::*;

  // An accepted pair always leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted input word");

  // An overflowed series reports the full capacity as pairs used.
  a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OVF) |-> out_data.pairs_used == N_BITS'(MAX_PAIRS))
    else $error("overflow result without full pair count");

  // Flat and overflow results carry a zero coefficient.
  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_VALID) |-> out_data.correlation == '0)
    else $error("special-case result with nonzero coefficient");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the output and leaves the block ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind pearson_correlation_engine_unit pce_checker u_pce_checker (.*);

// ===== tb/pearson_correlation_engine_unit_test.sv =====
`timescale 1ns / 1ps

module pearson_correlation_engine_unit_test;
  import pce_pkg::*;

  localparam int RANDOM_ITEMS  = 1875;
  localparam int QUIET_ITEMS   = 300;
  localparam int DRAIN_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 12000000;
  localparam int DIRECTED_ROWS = 25;

  // Content patterns for one random series.
  typedef enum int {
    MIX_FULL, MIX_SMALL, MIX_RISING, MIX_FALLING, MIX_FLAT, MIX_EXTREME
  } pair_mix_e;

  // One directed word, with a hand-written result where it is obvious.
  typedef struct packed {
    in_item_t  word;
    logic      typed;
    out_item_t result;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Single pairs are always flat.
    '{'{0, 0, 1'b1}, 1'b1, '{0, ST_FLAT, 1}},
    '{'{-32768, 32767, 1'b1}, 1'b1, '{0, ST_FLAT, 1}},
    // Identical series saturates at the top of the range.
    '{'{1, 1, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{2, 2, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{3, 3, 1'b1}, 1'b1, '{CORR_MAX, ST_VALID, 3}},
    // Mirrored series gives exactly minus one.
    '{'{1, -1, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{2, -2, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{3, -3, 1'b1}, 1'b1, '{-32768, ST_VALID, 3}},
    // Sample extremes.
    '{'{-32768, -32768, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{32767, 32767, 1'b1}, 1'b1, '{CORR_MAX, ST_VALID, 2}},
    '{'{-32768, 32767, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{32767, -32768, 1'b1}, 1'b1, '{-32768, ST_VALID, 2}},
    // Constant x, then constant y.
    '{'{5, 1, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{5, 2, 1'b1}, 1'b1, '{0, ST_FLAT, 2}},
    '{'{1, -7, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{9, -7, 1'b1}, 1'b1, '{0, ST_FLAT, 2}},
    // General series, checked against the predictor.
    '{'{100, 3, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{-200, 40, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{7, -9, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{32767, -1, 1'b1}, 1'b0, '{0, ST_VALID, 0}},
    '{'{-1, 0, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{0, -1, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{1, 1, 1'b1}, 1'b0, '{0, ST_VALID, 0}},
    '{'{-32768, 0, 1'b0}, 1'b0, '{0, ST_VALID, 0}},
    '{'{0, 32767, 1'b1}, 1'b0, '{0, ST_VALID, 0}}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  bit        gaps_on = 1'b1;
  int        mismatch_count = 0;
  int        stall_left = 0;
  out_item_t expected_coeffs[$];

  // Running series sums of the predictor.
  int unsigned series_pairs;
  longint      series_sx, series_sy, series_sxy, series_sxx, series_syy;
  bit          series_overflow;

  pearson_correlation_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Accumulate one pair; on a closing pair work out the coefficient exactly.
  function automatic bit correlate_pair(input in_item_t w, output out_item_t res);
    logic signed [255:0] n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w, num_w, vx_w, vy_w;
    logic [255:0]        mag_w, prod_w, tgt_w, cc_w;
    logic [16:0]         q, cand;
    longint              xs, ys;
    bit                  neg;
    int                  bit_pos;
    xs = longint'($signed(w.sample_x));
    ys = longint'($signed(w.sample_y));
    if (series_pairs < MAX_PAIRS) begin
      series_pairs++;
      series_sx  += xs;
      series_sy  += ys;
      series_sxy += xs * ys;
      series_sxx += xs * xs;
      series_syy += ys * ys;
    end else begin
      series_overflow = 1'b1;
    end
    res = '0;
    if (!w.last_pair) return 1'b0;

    res.status     = ST_VALID;
    res.pairs_used = N_BITS'(series_pairs);
    if (series_overflow) begin
      res.status = ST_OVF;
    end else begin
      n_w   = 256'(series_pairs);
      sx_w  = 256'(series_sx);
      sy_w  = 256'(series_sy);
      sxy_w = 256'(series_sxy);
      sxx_w = 256'(series_sxx);
      syy_w = 256'(series_syy);
      num_w = n_w * sxy_w - sx_w * sy_w;
      vx_w  = n_w * sxx_w - sx_w * sx_w;
      vy_w  = n_w * syy_w - sy_w * sy_w;
      if (vx_w == 0 || vy_w == 0) begin
        res.status = ST_FLAT;
      end else begin
        // Largest q with q^2 * vx * vy <= num^2 * 2^30, q at most 2^15.
        neg    = num_w[255];
        mag_w  = neg ? -num_w : num_w;
        prod_w = vx_w * vy_w;
        tgt_w  = (mag_w * mag_w) << 30;
        q      = '0;
        for (bit_pos = FRAC_BITS; bit_pos >= 0; bit_pos--) begin
          cand = q | (17'd1 << bit_pos);
          cc_w = 256'(cand) * 256'(cand);
          cc_w = cc_w * prod_w;
          if (cand <= 17'd32768 && cc_w <= tgt_w) q = cand;
        end
        if (!neg) begin
          res.correlation = (q > 17'd32767) ? CORR_MAX : CORR_W'(q);
        end else begin
          res.correlation = CORR_W'(17'h10000 - q);
        end
      end
    end

    series_pairs    = 0;
    series_sx       = 0;
    series_sy       = 0;
    series_sxy      = 0;
    series_sxx      = 0;
    series_syy      = 0;
    series_overflow = 1'b0;
    return 1'b1;
  endfunction

  // Present one word, hold it until accepted, then log what it should cause.
  task automatic send_pair(input in_item_t w, input bit use_typed,
                           input out_item_t typed_res);
    out_item_t pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (correlate_pair(w, pred)) begin
      expected_coeffs = {expected_coeffs, (use_typed ? typed_res : pred)};
    end
  endtask

  // Result side: compare each accepted word and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_coeffs.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        if (out_data.correlation !== expected_coeffs[0].correlation) begin
          $display("%0t: correlation mismatch, expected %0d, actual %0d", $time,
                   expected_coeffs[0].correlation, out_data.correlation);
          mismatch_count++;
        end
        if (out_data.status !== expected_coeffs[0].status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   expected_coeffs[0].status, out_data.status);
          mismatch_count++;
        end
        if (out_data.pairs_used !== expected_coeffs[0].pairs_used) begin
          $display("%0t: pairs_used mismatch, expected %0d, actual %0d", $time,
                   expected_coeffs[0].pairs_used, out_data.pairs_used);
          mismatch_count++;
        end
        void'(expected_coeffs.pop_front());
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hard stop if the run hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    in_item_t  word;
    int        row, sent, len, pick, k;
    pair_mix_e mix;
    logic signed [15:0] base, xv, yv;
    bit        side;

    series_pairs    = 0;
    series_sx       = 0;
    series_sy       = 0;
    series_sxy      = 0;
    series_sxx      = 0;
    series_syy      = 0;
    series_overflow = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_pair(DIRECTED[row].word, DIRECTED[row].typed, DIRECTED[row].result);
    end

    // Extreme samples fill the series to capacity, then one more pair overflows.
    for (k = 1; k <= MAX_PAIRS + 1; k++) begin
      word.sample_x  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      word.sample_y  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      word.last_pair = (k == MAX_PAIRS + 1);
      send_pair(word, 1'b0, '0);
    end

    // Random series, mostly short, with varied content.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 64);
      else len = $urandom_range(65, 300);
      mix     = pair_mix_e'($urandom_range(0, 5));
      gaps_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 4) != 0);
      base    = 16'($urandom);
      side    = 1'($urandom_range(0, 1));
      for (k = 1; k <= len; k++) begin
        case (mix)
          MIX_SMALL: begin
            xv = 16'($urandom_range(0, 8) - 4);
            yv = 16'($urandom_range(0, 8) - 4);
          end
          MIX_RISING: begin
            xv = 16'($urandom_range(0, 32000) - 16000);
            yv = 16'(xv + ($urandom_range(0, 1000) - 500));
          end
          MIX_FALLING: begin
            xv = 16'($urandom_range(0, 32000) - 16000);
            yv = 16'(-xv + ($urandom_range(0, 1000) - 500));
          end
          MIX_FLAT: begin
            xv = side ? base : 16'($urandom);
            yv = side ? 16'($urandom) : base;
          end
          MIX_EXTREME: begin
            xv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            yv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          end
          default: begin
            xv = 16'($urandom);
            yv = 16'($urandom);
          end
        endcase
        word.sample_x  = xv;
        word.sample_y  = yv;
        word.last_pair = (k == len);
        send_pair(word, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let every pending result arrive, then allow for stray words.
    while (expected_coeffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pce_pkg.sv
hdl/pce_accum.sv
hdl/pce_isqrt.sv
hdl/pce_finish.sv
hdl/pearson_correlation_engine_unit.sv
hdl/pce_checker.sv
tb/pearson_correlation_engine_unit_test.sv
